>>> src/mbd_pkg.sv
// Shared types, codes and constants of the MIDI byte stream decoder.
package mbd_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        CLS_DATA,
        CLS_RT,
        CLS_CHAN,
        CLS_SYSEX_START,
        CLS_QF,
        CLS_SPP,
        CLS_SONG,
        CLS_TUNE,
        CLS_IGNORE
    } cls_t;

    typedef struct packed {
        cls_t       cls;
        logic [6:0] value;
        logic       prio;
    } beat_t;

    localparam logic [1:0] KIND_MSG  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;

    localparam logic [6:0] TYPE_NOTE_OFF  = 7'h00;
    localparam logic [6:0] TYPE_NOTE_ON   = 7'h10;
    localparam logic [6:0] TYPE_POLY      = 7'h20;
    localparam logic [6:0] TYPE_CC        = 7'h30;
    localparam logic [6:0] TYPE_PROG      = 7'h40;
    localparam logic [6:0] TYPE_MONO      = 7'h50;
    localparam logic [6:0] TYPE_BEND      = 7'h60;
    localparam logic [6:0] TYPE_SYSEX     = 7'h70;
    localparam logic [6:0] TYPE_QF        = 7'h71;
    localparam logic [6:0] TYPE_SPP       = 7'h72;
    localparam logic [6:0] TYPE_SONG      = 7'h73;
    localparam logic [6:0] TYPE_TUNE      = 7'h76;
    localparam logic [6:0] TYPE_RT_FIRST  = 7'h78;
    localparam logic [6:0] TYPE_RESET     = 7'h7f;

    localparam logic [15:0] BEND_OFFSET = 16'h2000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [6:0]         type_code;
        logic [4:0]         channel;
        logic [6:0]         first_data;
        logic [6:0]         second_data;
        logic signed [15:0] wide_value;
        logic [8:0]         sequence_index;
        logic               length_overflowed;
        logic               priority_res;
        logic               last;
    } res_t;

endpackage

>>> src/midi_byte_stream_decoder.sv
// Top level of the MIDI byte stream decoder: front end, beat queue and parser.
// One MIDI byte is taken per beat on the input channel and decoded with running
// status into messages on the output channel; every byte that yields results
// marks its final result with last. The sustained rate is one byte per cycle
// while the output is not stalled and no exclusive message is being closed. A
// status byte that closes an open exclusive message is first reported as the
// exclusive stop and then parsed again from idle, because the parser back end
// drives a single output register. A byte waits in a queue of QUEUE_DEPTH
// entries and is parsed once it is at the head of the queue and the output is
// free; its result is held in the output register, and a stalled output stops
// the parser and then the input once the queue is full. Real-time bytes are
// reported in stream order and carry priority_res when the configuration bit is
// set; the user must write the bit only while idle, as the block does not enforce it.
module midi_byte_stream_decoder #(
    parameter int QUEUE_DEPTH = mbd_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         midi_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [6:0]         type_code,
    output logic [4:0]         channel,
    output logic [6:0]         first_data,
    output logic [6:0]         second_data,
    output logic signed [15:0] wide_value,
    output logic [8:0]         sequence_index,
    output logic               length_overflowed,
    output logic               priority_res,
    output logic               last
);

    mbd_pkg::beat_t in_beat;
    mbd_pkg::beat_t head;
    mbd_pkg::res_t  res;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    mbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .midi_byte (midi_byte),
        .beat      (in_beat)
    );

    mbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_beat  (in_beat),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (head)
    );

    mbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (head),
        .pop        (q_pop),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .res        (res)
    );

    assign in_ready          = !q_full;
    assign kind              = res.kind;
    assign type_code         = res.type_code;
    assign channel           = res.channel;
    assign first_data        = res.first_data;
    assign second_data       = res.second_data;
    assign wide_value        = res.wide_value;
    assign sequence_index    = res.sequence_index;
    assign length_overflowed = res.length_overflowed;
    assign priority_res      = res.priority_res;
    assign last              = res.last;

    // A stop that is not the last result leaves its status byte queued.
    a_stop_keeps_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == mbd_pkg::KIND_STOP && !last |-> q_valid)
        else $error("exclusive stop without a pending status byte");

    a_prio_is_realtime: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && priority_res |->
            kind == mbd_pkg::KIND_MSG && type_code >= mbd_pkg::TYPE_RT_FIRST &&
            channel == 5'd0 && last)
        else $error("priority flag on a result that is not real-time");

    a_overflow_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_overflowed |-> kind == mbd_pkg::KIND_STOP)
        else $error("overflow flag outside an exclusive stop");

    a_sysex_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != mbd_pkg::KIND_MSG |-> type_code == 7'd0 && channel == 5'd0)
        else $error("exclusive result carries a message type or channel");

endmodule

>>> src/mbd_front.sv
// Input side: configuration register and byte classification.
module mbd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic              cfg_wdata,
    input  logic [7:0]        midi_byte,
    output mbd_pkg::beat_t    beat
);

    logic realtime_priority_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            realtime_priority_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            realtime_priority_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        beat.value = midi_byte[6:0];
        beat.prio  = realtime_priority_reg;
        priority if (!midi_byte[7])
        begin
            beat.cls = mbd_pkg::CLS_DATA;
        end
        else if (midi_byte[6:3] == 4'hf)
        begin
            beat.cls = mbd_pkg::CLS_RT;
        end
        else if (midi_byte[6:4] != 3'h7)
        begin
            beat.cls = mbd_pkg::CLS_CHAN;
        end
        else
        begin
            unique case (midi_byte[2:0])
                3'd0:    beat.cls = mbd_pkg::CLS_SYSEX_START;
                3'd1:    beat.cls = mbd_pkg::CLS_QF;
                3'd2:    beat.cls = mbd_pkg::CLS_SPP;
                3'd3:    beat.cls = mbd_pkg::CLS_SONG;
                3'd6:    beat.cls = mbd_pkg::CLS_TUNE;
                default: beat.cls = mbd_pkg::CLS_IGNORE;
            endcase
        end
    end

endmodule

>>> src/mbd_queue.sv
// Short first-in first-out queue of classified beats between front and back.
module mbd_queue #(
    parameter int DEPTH = mbd_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mbd_pkg::beat_t push_beat,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output mbd_pkg::beat_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mbd_pkg::beat_t entries_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push;
    logic           do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

>>> src/mbd_back.sv
// Running status parser that turns queued beats into decoded results.
module mbd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  mbd_pkg::beat_t head,
    output logic           pop,
    input  logic           out_ready,
    output logic           out_valid,
    output mbd_pkg::res_t  res
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_ON, ST_ON_NOTE, ST_OFF, ST_OFF_NOTE, ST_CC, ST_CC_CTRL,
        ST_PROG, ST_BEND, ST_BEND_LSB, ST_MONO, ST_POLY, ST_POLY_NOTE,
        ST_QF, ST_SPP, ST_SPP_LSB, ST_SONG, ST_SYSEX
    } state_t;

    state_t         state_reg, state_next, eff_state;
    logic [4:0]     channel_reg, channel_next;
    logic [6:0]     held_reg, held_next;
    logic [6:0]     bend_reg, bend_next;
    logic [6:0]     pos_reg, pos_next;
    logic [15:0]    count_reg, count_next;
    logic           out_valid_reg;
    mbd_pkg::res_t  res_reg, res_new;
    logic           emit;
    logic           consume;
    logic           fire;
    logic [6:0]     v;

    assign v    = head.value;
    assign fire = head_valid && (!emit || !out_valid_reg || out_ready);
    assign pop  = fire && consume;

    always_comb
    begin
        state_next   = state_reg;
        channel_next = channel_reg;
        held_next    = held_reg;
        bend_next    = bend_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        res_new      = '0;
        res_new.last = 1'b1;
        emit         = 1'b0;
        consume      = 1'b1;
        eff_state    = (state_reg != ST_IDLE && head.cls != mbd_pkg::CLS_DATA) ?
                       ST_IDLE : state_reg;
        if (head.cls == mbd_pkg::CLS_RT)
        begin
            emit                 = 1'b1;
            res_new.type_code    = v;
            res_new.priority_res = head.prio;
            if (v == mbd_pkg::TYPE_RESET)
            begin
                state_next = ST_IDLE;
            end
        end
        else if (state_reg == ST_SYSEX && head.cls != mbd_pkg::CLS_DATA)
        begin
            // The closing status byte stays queued and is parsed again from idle.
            emit                      = 1'b1;
            consume                   = 1'b0;
            res_new.kind              = mbd_pkg::KIND_STOP;
            res_new.wide_value        = {1'b0, count_reg[14:0]};
            res_new.length_overflowed = count_reg[15];
            res_new.last              = !(head.cls == mbd_pkg::CLS_SYSEX_START ||
                                          head.cls == mbd_pkg::CLS_TUNE);
            count_next                = '0;
            state_next                = ST_IDLE;
        end
        else
        begin
            unique case (eff_state)
                ST_ON, ST_OFF, ST_CC, ST_POLY:
                begin
                    held_next  = v;
                    state_next = state_t'(eff_state + 5'd1);
                end
                ST_ON_NOTE, ST_OFF_NOTE, ST_CC_CTRL, ST_POLY_NOTE:
                begin
                    emit                = 1'b1;
                    res_new.channel     = channel_reg;
                    res_new.first_data  = held_reg;
                    res_new.second_data = v;
                    state_next          = state_t'(eff_state - 5'd1);
                    unique case (eff_state)
                        ST_ON_NOTE:  res_new.type_code = mbd_pkg::TYPE_NOTE_ON;
                        ST_OFF_NOTE: res_new.type_code = mbd_pkg::TYPE_NOTE_OFF;
                        ST_CC_CTRL:  res_new.type_code = mbd_pkg::TYPE_CC;
                        default:     res_new.type_code = mbd_pkg::TYPE_POLY;
                    endcase
                end
                ST_PROG:
                begin
                    emit               = 1'b1;
                    res_new.type_code  = mbd_pkg::TYPE_PROG;
                    res_new.channel    = channel_reg;
                    res_new.first_data = v;
                end
                ST_MONO:
                begin
                    emit               = 1'b1;
                    res_new.type_code  = mbd_pkg::TYPE_MONO;
                    res_new.channel    = channel_reg;
                    res_new.first_data = v;
                end
                ST_BEND:
                begin
                    bend_next  = v;
                    state_next = ST_BEND_LSB;
                end
                ST_BEND_LSB:
                begin
                    emit               = 1'b1;
                    res_new.type_code  = mbd_pkg::TYPE_BEND;
                    res_new.channel    = channel_reg;
                    res_new.wide_value = {2'b00, v, bend_reg} - mbd_pkg::BEND_OFFSET;
                    state_next         = ST_BEND;
                end
                ST_QF:
                begin
                    emit                = 1'b1;
                    res_new.type_code   = mbd_pkg::TYPE_QF;
                    res_new.first_data  = {4'b0000, v[6:4]};
                    res_new.second_data = {3'b000, v[3:0]};
                    state_next          = ST_IDLE;
                end
                ST_SPP:
                begin
                    pos_next   = v;
                    state_next = ST_SPP_LSB;
                end
                ST_SPP_LSB:
                begin
                    emit               = 1'b1;
                    res_new.type_code  = mbd_pkg::TYPE_SPP;
                    res_new.wide_value = {2'b00, v, pos_reg};
                    state_next         = ST_IDLE;
                end
                ST_SONG:
                begin
                    emit               = 1'b1;
                    res_new.type_code  = mbd_pkg::TYPE_SONG;
                    res_new.first_data = v;
                    state_next         = ST_IDLE;
                end
                ST_SYSEX:
                begin
                    emit                   = 1'b1;
                    res_new.kind           = mbd_pkg::KIND_DATA;
                    res_new.first_data     = v;
                    res_new.sequence_index = count_reg[8:0];
                    count_next = {count_reg[15] | (&count_reg[14:0]),
                                  count_reg[14:0] + 15'd1};
                end
                default:
                begin
                    state_next = ST_IDLE;
                    unique case (head.cls)
                        mbd_pkg::CLS_CHAN:
                        begin
                            channel_next = {1'b0, v[3:0]} + 5'd1;
                            unique case (v[6:4])
                                3'd0:    state_next = ST_OFF;
                                3'd1:    state_next = ST_ON;
                                3'd2:    state_next = ST_POLY;
                                3'd3:    state_next = ST_CC;
                                3'd4:    state_next = ST_PROG;
                                3'd5:    state_next = ST_MONO;
                                3'd6:    state_next = ST_BEND;
                                default: state_next = ST_IDLE;
                            endcase
                        end
                        mbd_pkg::CLS_QF:   state_next = ST_QF;
                        mbd_pkg::CLS_SPP:  state_next = ST_SPP;
                        mbd_pkg::CLS_SONG: state_next = ST_SONG;
                        mbd_pkg::CLS_TUNE:
                        begin
                            emit              = 1'b1;
                            res_new.type_code = mbd_pkg::TYPE_TUNE;
                        end
                        mbd_pkg::CLS_SYSEX_START:
                        begin
                            emit              = 1'b1;
                            res_new.type_code = mbd_pkg::TYPE_SYSEX;
                            count_next        = '0;
                            state_next        = ST_SYSEX;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            channel_reg   <= '0;
            held_reg      <= '0;
            bend_reg      <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (fire)
            begin
                state_reg   <= state_next;
                channel_reg <= channel_next;
                held_reg    <= held_next;
                bend_reg    <= bend_next;
                pos_reg     <= pos_next;
                count_reg   <= count_next;
            end
            if (fire && emit)
            begin
                out_valid_reg <= 1'b1;
                res_reg       <= res_new;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

>>> tb/sv/midi_decode_check.sv
// Monitor for the MIDI byte stream decoder: predicts results from accepted bytes and compares.
module midi_decode_check
    import mbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         midi_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         kind,
    input  logic [6:0]         type_code,
    input  logic [4:0]         channel,
    input  logic [6:0]         first_data,
    input  logic [6:0]         second_data,
    input  logic signed [15:0] wide_value,
    input  logic [8:0]         sequence_index,
    input  logic               length_overflowed,
    input  logic               priority_res,
    input  logic               last,
    output int                 mismatches,
    output int                 msgs_outstanding
);

    typedef enum logic [4:0] {
        PS_IDLE,
        PS_ON,
        PS_ON_NOTE,
        PS_OFF,
        PS_OFF_NOTE,
        PS_CC,
        PS_CC_CTRL,
        PS_PROG,
        PS_BEND,
        PS_BEND_LSB,
        PS_MONO,
        PS_POLY,
        PS_POLY_NOTE,
        PS_QF,
        PS_SPP,
        PS_SPP_LSB,
        PS_SONG,
        PS_SYSEX
    } parse_t;

    parse_t      ps;
    logic [4:0]  chan_r;
    logic [6:0]  held;
    logic [6:0]  bend_lsb;
    logic [6:0]  pos_lsb;
    logic [15:0] excl_count;
    logic        rt_priority;
    res_t        expected_msgs[$];

    function automatic res_t make_msg(input logic [1:0] k, input logic [6:0] t,
                                      input logic [4:0] c, input logic [6:0] d1,
                                      input logic [6:0] d2, input logic [15:0] w,
                                      input logic [8:0] s, input logic o, input logic p);
        res_t r;
        r.kind = k;
        r.type_code = t;
        r.channel = c;
        r.first_data = d1;
        r.second_data = d2;
        r.wide_value = w;
        r.sequence_index = s;
        r.length_overflowed = o;
        r.priority_res = p;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic res_t chan_msg(input logic [6:0] t, input logic [6:0] d1,
                                      input logic [6:0] d2, input logic [15:0] w);
        return make_msg(KIND_MSG, t, chan_r, d1, d2, w, 9'd0, 1'b0, 1'b0);
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        res_t       made[$];
        res_t       tail;
        logic [6:0] t;
        logic       is_data;
        is_data = !b[7];
        if (b >= 8'hF8)
        begin
            made.push_back(make_msg(KIND_MSG, b[6:0], 5'd0, 7'd0, 7'd0, 16'd0, 9'd0, 1'b0,
                                    rt_priority));
            if (b[6:0] == TYPE_RESET)
                ps = PS_IDLE;
        end
        else
        begin
            if (ps != PS_IDLE && !is_data)
            begin
                if (ps == PS_SYSEX)
                begin
                    made.push_back(make_msg(KIND_STOP, 7'd0, 5'd0, 7'd0, 7'd0,
                                            {1'b0, excl_count[14:0]}, 9'd0,
                                            excl_count[15], 1'b0));
                    excl_count = 16'd0;
                end
                ps = PS_IDLE;
            end
            case (ps)
                PS_ON:
                begin
                    held = b[6:0];
                    ps = PS_ON_NOTE;
                end
                PS_OFF:
                begin
                    held = b[6:0];
                    ps = PS_OFF_NOTE;
                end
                PS_CC:
                begin
                    held = b[6:0];
                    ps = PS_CC_CTRL;
                end
                PS_POLY:
                begin
                    held = b[6:0];
                    ps = PS_POLY_NOTE;
                end
                PS_ON_NOTE:
                begin
                    made.push_back(chan_msg(TYPE_NOTE_ON, held, b[6:0], 16'd0));
                    ps = PS_ON;
                end
                PS_OFF_NOTE:
                begin
                    made.push_back(chan_msg(TYPE_NOTE_OFF, held, b[6:0], 16'd0));
                    ps = PS_OFF;
                end
                PS_CC_CTRL:
                begin
                    made.push_back(chan_msg(TYPE_CC, held, b[6:0], 16'd0));
                    ps = PS_CC;
                end
                PS_POLY_NOTE:
                begin
                    made.push_back(chan_msg(TYPE_POLY, held, b[6:0], 16'd0));
                    ps = PS_POLY;
                end
                PS_PROG:
                begin
                    made.push_back(chan_msg(TYPE_PROG, b[6:0], 7'd0, 16'd0));
                end
                PS_MONO:
                begin
                    made.push_back(chan_msg(TYPE_MONO, b[6:0], 7'd0, 16'd0));
                end
                PS_BEND:
                begin
                    bend_lsb = b[6:0];
                    ps = PS_BEND_LSB;
                end
                PS_BEND_LSB:
                begin
                    made.push_back(chan_msg(TYPE_BEND, 7'd0, 7'd0,
                                            {2'b00, b[6:0], bend_lsb} - BEND_OFFSET));
                    ps = PS_BEND;
                end
                PS_QF:
                begin
                    made.push_back(make_msg(KIND_MSG, TYPE_QF, 5'd0, {4'd0, b[6:4]},
                                            {3'd0, b[3:0]}, 16'd0, 9'd0, 1'b0, 1'b0));
                    ps = PS_IDLE;
                end
                PS_SPP:
                begin
                    pos_lsb = b[6:0];
                    ps = PS_SPP_LSB;
                end
                PS_SPP_LSB:
                begin
                    made.push_back(make_msg(KIND_MSG, TYPE_SPP, 5'd0, 7'd0, 7'd0,
                                            {2'b00, b[6:0], pos_lsb}, 9'd0, 1'b0, 1'b0));
                    ps = PS_IDLE;
                end
                PS_SONG:
                begin
                    made.push_back(make_msg(KIND_MSG, TYPE_SONG, 5'd0, b[6:0], 7'd0, 16'd0,
                                            9'd0, 1'b0, 1'b0));
                    ps = PS_IDLE;
                end
                PS_SYSEX:
                begin
                    made.push_back(make_msg(KIND_DATA, 7'd0, 5'd0, b[6:0], 7'd0, 16'd0,
                                            excl_count[8:0], 1'b0, 1'b0));
                    excl_count = (excl_count + 16'd1) | (excl_count & 16'h8000);
                end
                default:
                begin
                    ps = PS_IDLE;
                    if (!is_data)
                    begin
                        t = (b[6:4] == 3'b111) ? b[6:0] : {b[6:4], 4'd0};
                        if (t < TYPE_SYSEX)
                            chan_r = {1'b0, b[3:0]} + 5'd1;
                        case (t)
                            TYPE_NOTE_OFF: ps = PS_OFF;
                            TYPE_NOTE_ON:  ps = PS_ON;
                            TYPE_POLY:     ps = PS_POLY;
                            TYPE_CC:       ps = PS_CC;
                            TYPE_PROG:     ps = PS_PROG;
                            TYPE_MONO:     ps = PS_MONO;
                            TYPE_BEND:     ps = PS_BEND;
                            TYPE_QF:       ps = PS_QF;
                            TYPE_SPP:      ps = PS_SPP;
                            TYPE_SONG:     ps = PS_SONG;
                            TYPE_TUNE:
                            begin
                                made.push_back(make_msg(KIND_MSG, TYPE_TUNE, 5'd0, 7'd0, 7'd0,
                                                        16'd0, 9'd0, 1'b0, 1'b0));
                            end
                            TYPE_SYSEX:
                            begin
                                made.push_back(make_msg(KIND_MSG, TYPE_SYSEX, 5'd0, 7'd0,
                                                        7'd0, 16'd0, 9'd0, 1'b0, 1'b0));
                                excl_count = 16'd0;
                                ps = PS_SYSEX;
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end
        if (made.size() > 0)
        begin
            tail = made.pop_back();
            tail.last = 1'b1;
            made.push_back(tail);
        end
        foreach (made[i])
            expected_msgs.push_back(made[i]);
    endtask

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        mismatches++;
        $display("mismatch: %s got %0d expected %0d", what, got_v, want_v);
    endtask

    task automatic check_result();
        res_t got;
        res_t want;
        got.kind = kind;
        got.type_code = type_code;
        got.channel = channel;
        got.first_data = first_data;
        got.second_data = second_data;
        got.wide_value = wide_value;
        got.sequence_index = sequence_index;
        got.length_overflowed = length_overflowed;
        got.priority_res = priority_res;
        got.last = last;
        if (expected_msgs.size() == 0)
        begin
            report_mismatch("message with nothing expected, type_code", got.type_code, 0);
        end
        else
        begin
            want = expected_msgs.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", got.kind, want.kind);
            if (got.type_code !== want.type_code)
                report_mismatch("type_code", got.type_code, want.type_code);
            if (got.channel !== want.channel)
                report_mismatch("channel", got.channel, want.channel);
            if (got.first_data !== want.first_data)
                report_mismatch("first_data", got.first_data, want.first_data);
            if (got.second_data !== want.second_data)
                report_mismatch("second_data", got.second_data, want.second_data);
            if (got.wide_value !== want.wide_value)
                report_mismatch("wide_value", got.wide_value, want.wide_value);
            if (got.sequence_index !== want.sequence_index)
                report_mismatch("sequence_index", got.sequence_index, want.sequence_index);
            if (got.length_overflowed !== want.length_overflowed)
                report_mismatch("length_overflowed", got.length_overflowed,
                                want.length_overflowed);
            if (got.priority_res !== want.priority_res)
                report_mismatch("priority_res", got.priority_res, want.priority_res);
            if (got.last !== want.last)
                report_mismatch("last", got.last, want.last);
        end
    endtask

    // An accepted input beat is decoded before the output beat of the same edge is
    // compared, since no result can leave in the cycle its byte is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps = PS_IDLE;
            chan_r = 5'd0;
            held = 7'd0;
            bend_lsb = 7'd0;
            pos_lsb = 7'd0;
            excl_count = 16'd0;
            rt_priority = 1'b0;
            mismatches = 0;
            expected_msgs.delete();
        end
        else
        begin
            if (cfg_wen)
                rt_priority = cfg_wdata;
            if (in_valid && in_ready)
                decode_byte(midi_byte);
            if (out_valid && out_ready)
                check_result();
        end
        msgs_outstanding = expected_msgs.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the decoder testbench: clock, reset, byte stimulus, flow control and the verdict.
module tb_top;
    import mbd_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [7:0] END_OF_EXCL = 8'hF7;

    logic               clk;
    logic               rst_n;
    logic               cfg_wen;
    logic               cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         midi_byte;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         kind;
    logic [6:0]         type_code;
    logic [4:0]         channel;
    logic [6:0]         first_data;
    logic [6:0]         second_data;
    logic signed [15:0] wide_value;
    logic [8:0]         sequence_index;
    logic               length_overflowed;
    logic               priority_res;
    logic               last;
    int                 mismatches;
    int                 msgs_outstanding;

    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_req;
    int   items_sent;
    int   quiet_cycles;

    logic [7:0] directed_bytes[] = '{
        8'h9F, 8'h7F, 8'h00, 8'h00, 8'h7F, 8'h80, 8'h3C, 8'h40,
        8'hE0, 8'h00, 8'h00, 8'h7F, 8'h7F, 8'hF2, 8'h7F, 8'h7F,
        8'hF0, 8'h7F, 8'h90, 8'hF8, 8'h3C, 8'hFF, 8'hF6, 8'hF4,
        8'hF5, 8'hF7, 8'h12, 8'hFD
    };

    logic [6:0] chan_types[7] = '{
        TYPE_NOTE_OFF, TYPE_NOTE_ON, TYPE_POLY, TYPE_CC, TYPE_PROG, TYPE_MONO, TYPE_BEND
    };

    midi_byte_stream_decoder i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wen           (cfg_wen),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .midi_byte         (midi_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .kind              (kind),
        .type_code         (type_code),
        .channel           (channel),
        .first_data        (first_data),
        .second_data       (second_data),
        .wide_value        (wide_value),
        .sequence_index    (sequence_index),
        .length_overflowed (length_overflowed),
        .priority_res      (priority_res),
        .last              (last)
    );

    midi_decode_check i_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wen           (cfg_wen),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .midi_byte         (midi_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .kind              (kind),
        .type_code         (type_code),
        .channel           (channel),
        .first_data        (first_data),
        .second_data       (second_data),
        .wide_value        (wide_value),
        .sequence_index    (sequence_index),
        .length_overflowed (length_overflowed),
        .priority_res      (priority_res),
        .last              (last),
        .mismatches        (mismatches),
        .msgs_outstanding  (msgs_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : receiver_flow
        logic hold_taken;
        hold_taken = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] data_byte();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'h7F;
        return 8'($urandom_range(127));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        midi_byte = b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (msgs_outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_priority(input logic v);
        wait_drained();
        cfg_wen = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_wen = 1'b0;
    endtask

    task automatic send_message();
        logic [7:0] bytes[$];
        logic [6:0] op;
        logic [3:0] ch;
        int         pick;
        int         n;
        pick = $urandom_range(99);
        ch = 4'($urandom_range(15));
        if (pick < 15)
        begin
            bytes.push_back(8'($urandom_range(255)));
        end
        else if (pick < 55)
        begin
            op = chan_types[$urandom_range(6)];
            bytes.push_back({1'b1, op[6:4], ch});
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                bytes.push_back(data_byte());
                if (op != TYPE_PROG && op != TYPE_MONO)
                    bytes.push_back(data_byte());
            end
            if ($urandom_range(9) == 0)
                void'(bytes.pop_back());
        end
        else if (pick < 62)
        begin
            bytes.push_back({1'b1, TYPE_QF});
            bytes.push_back(8'($urandom_range(127)));
        end
        else if (pick < 68)
        begin
            bytes.push_back({1'b1, TYPE_SPP});
            bytes.push_back(data_byte());
            bytes.push_back(data_byte());
        end
        else if (pick < 72)
        begin
            bytes.push_back({1'b1, TYPE_SONG});
            bytes.push_back(data_byte());
        end
        else if (pick < 75)
        begin
            bytes.push_back({1'b1, TYPE_TUNE});
        end
        else if (pick < 90)
        begin
            bytes.push_back({1'b1, TYPE_SYSEX});
            n = $urandom_range(0, 24);
            repeat (n) bytes.push_back(data_byte());
            if ($urandom_range(4) == 0)
                bytes.push_back(8'($urandom_range(8'h80, 8'hF7)));
            else
                bytes.push_back(END_OF_EXCL);
        end
        else
        begin
            bytes.push_back(8'($urandom_range({1'b1, TYPE_RT_FIRST}, {1'b1, TYPE_RESET})));
        end
        foreach (bytes[i])
        begin
            if ($urandom_range(24) == 0)
                send_byte(8'($urandom_range({1'b1, TYPE_RT_FIRST}, {1'b1, TYPE_RESET})));
            send_byte(bytes[i]);
        end
    endtask

    task automatic send_traffic(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
            send_message();
    endtask

    task automatic send_long_exclusive(input int length);
        send_byte({1'b1, TYPE_SYSEX});
        repeat (length) send_byte(8'($urandom_range(127)));
        send_byte(END_OF_EXCL);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = 1'b0;
        in_valid = 1'b0;
        midi_byte = 8'h00;
        hold_req = 1'b0;
        items_sent = 0;
        send_idle_pct = 9;
        recv_idle_pct = 46;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_priority(1'b1);
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        wait_drained();
        send_traffic(100);
        wait_drained();
        send_traffic(100);

        write_priority(1'b0);
        send_idle_pct = 46;
        recv_idle_pct = 9;
        send_traffic(100);
        hold_req = 1'b1;
        send_traffic(130);

        write_priority(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_traffic(90);
        send_long_exclusive(520);

        write_priority(1'b0);
        send_traffic(30);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && msgs_outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
